@@ hw/rtl/hsd_pkg.sv @@
// Shared constants, types and code-layout helpers for the Hamming SEC decoder.
// Depends on nothing; every decoder module refers to it by scoped names.
package hsd_pkg;

    // Code geometry: parity count is fixed at build time.
    localparam int PARITY_BITS = 6;
    localparam int CODE_LEN    = (1 << PARITY_BITS) - 1;
    localparam int DATA_LEN    = CODE_LEN - PARITY_BITS;

    // Port widths set by the interface.
    localparam int CODE_W  = 63;
    localparam int DATA_W  = 57;
    localparam int POS_W   = 6;
    localparam int DBITS_W = 6;

    localparam logic [DBITS_W-1:0] DATA_BITS_RESET = DBITS_W'(57);

    // Decoupling queue between front and back.
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // One classified beat: the masked received word and its syndrome.
    typedef struct packed {
        logic [CODE_W-1:0] word;
        logic [POS_W-1:0]  syndrome;
    } hsd_item_t;

    // Queue occupancy as seen by its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } hsd_q_status_t;

    // Mask of the code positions that exist for this parity count.
    function automatic logic [CODE_W-1:0] code_mask();
        logic [CODE_W-1:0] m;
        m = '0;
        for (int j = 0; j < CODE_W; j++)
        begin
            m[j] = (j < CODE_LEN);
        end
        return m;
    endfunction

    // Positions covered by parity bit b: every position whose bit b is set.
    function automatic logic [CODE_W-1:0] cover_mask(input int b);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int j = 0; j < CODE_W; j++)
        begin
            m[j] = (j < CODE_LEN) && ((((j + 1) >> b) & 1) == 1);
        end
        return m;
    endfunction

endpackage

@@ hw/rtl/hsd_front.sv @@
// Front stage of the Hamming SEC decoder: accepts codewords and computes syndromes.
// Depends on hsd_pkg; feeds classified beats into hsd_queue.
module hsd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [hsd_pkg::CODE_W-1:0]     codeword,
    input  hsd_pkg::hsd_q_status_t         q_status,
    output logic                           q_wr,
    output hsd_pkg::hsd_item_t             q_wdata
);

    logic               front_valid_reg;
    logic               front_valid_next;
    hsd_pkg::hsd_item_t front_item_reg;
    hsd_pkg::hsd_item_t front_item_next;
    logic               accept;

    // Handshake: the stage stalls only when it holds a beat the queue cannot take.
    assign full   = front_valid_reg && q_status.full;
    assign accept = push && !full;
    assign q_wr   = front_valid_reg && !q_status.full;

    // Syndrome: each bit is the parity over the positions that bit covers.
    always_comb
    begin
        front_item_next.word = codeword & hsd_pkg::code_mask();
        for (int b = 0; b < hsd_pkg::POS_W; b++)
        begin
            front_item_next.syndrome[b] = ^(front_item_next.word & hsd_pkg::cover_mask(b));
        end
    end

    // Valid tracking for the stage register.
    always_comb
    begin
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (q_wr)
        begin
            front_valid_next = 1'b0;
        end
        else
        begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // Payload register, loaded on each accepted beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_item_reg <= front_item_next;
        end
    end

    assign q_wdata = front_item_reg;

endmodule

@@ hw/rtl/hsd_queue.sv @@
// Short FIFO of classified beats between the decoder front and back stages.
// Depends on hsd_pkg for the item type and depth.
module hsd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr,
    input  hsd_pkg::hsd_item_t     wdata,
    input  logic                   rd,
    output hsd_pkg::hsd_item_t     rdata,
    output hsd_pkg::hsd_q_status_t status
);

    hsd_pkg::hsd_item_t                entries [hsd_pkg::QUEUE_DEPTH];
    logic [hsd_pkg::QUEUE_AW-1:0]      wr_ptr_reg;
    logic [hsd_pkg::QUEUE_AW-1:0]      wr_ptr_next;
    logic [hsd_pkg::QUEUE_AW-1:0]      rd_ptr_reg;
    logic [hsd_pkg::QUEUE_AW-1:0]      rd_ptr_next;
    logic [hsd_pkg::QUEUE_AW:0]        count_reg;
    logic [hsd_pkg::QUEUE_AW:0]        count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign status.full  = (count_reg == (hsd_pkg::QUEUE_AW + 1)'(hsd_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr && !status.full;
    assign do_rd        = rd && !status.empty;
    assign rdata        = entries[rd_ptr_reg];

    // Pointer and count updates.
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hw/rtl/hsd_back.sv @@
// Back stage of the Hamming SEC decoder: corrects, extracts and masks data bits.
// Depends on hsd_pkg; drains hsd_queue and holds the result register.
module hsd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hsd_pkg::DBITS_W-1:0]     cfg_wdata,
    input  hsd_pkg::hsd_q_status_t          q_status,
    input  hsd_pkg::hsd_item_t              q_rdata,
    output logic                            q_rd,
    input  logic                            pop,
    output logic                            empty,
    output logic [hsd_pkg::DATA_W-1:0]      data_out,
    output logic [hsd_pkg::POS_W-1:0]       error_position,
    output logic                            error_found
);

    logic [hsd_pkg::DBITS_W-1:0] data_bits_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [hsd_pkg::DATA_W-1:0]  data_out_reg;
    logic [hsd_pkg::DATA_W-1:0]  data_out_next;
    logic [hsd_pkg::POS_W-1:0]   error_position_reg;
    logic                        error_found_reg;
    logic [hsd_pkg::CODE_W-1:0]  flip;
    logic [hsd_pkg::CODE_W-1:0]  corrected;
    logic [hsd_pkg::DATA_W-1:0]  extracted;
    logic [hsd_pkg::DATA_W-1:0]  keep;
    logic                        advance;

    // Pack the non-power-of-two positions in order; the mapping is fixed wiring.
    function automatic logic [hsd_pkg::DATA_W-1:0] extract(
        input logic [hsd_pkg::CODE_W-1:0] w
    );
        logic [hsd_pkg::DATA_W-1:0] d;
        int                         idx;
        d   = '0;
        idx = 0;
        for (int p = 1; p <= hsd_pkg::CODE_LEN; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                if (idx < hsd_pkg::DATA_W)
                begin
                    d[idx] = w[p-1];
                end
                idx++;
            end
        end
        return d;
    endfunction

    // A beat moves from the queue whenever the result register is free or draining.
    assign advance = !q_status.empty && (!out_valid_reg || pop);
    assign q_rd    = advance;
    assign empty   = !out_valid_reg;

    // Correction: flip the position named by the syndrome, if any.
    always_comb
    begin
        for (int j = 0; j < hsd_pkg::CODE_W; j++)
        begin
            flip[j] = (q_rdata.syndrome == hsd_pkg::POS_W'(j + 1));
        end
        corrected = q_rdata.word ^ flip;
        extracted = extract(corrected);
        for (int i = 0; i < hsd_pkg::DATA_W; i++)
        begin
            keep[i] = (hsd_pkg::DBITS_W'(i) < data_bits_reg);
        end
        data_out_next = extracted & keep;
    end

    // Result register valid flag.
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            data_bits_reg <= hsd_pkg::DATA_BITS_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                data_bits_reg <= cfg_wdata;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_out_reg       <= data_out_next;
            error_position_reg <= q_rdata.syndrome;
            error_found_reg    <= (q_rdata.syndrome != '0);
        end
    end

    assign data_out       = data_out_reg;
    assign error_position = error_position_reg;
    assign error_found    = error_found_reg;

endmodule

@@ hw/rtl/hamming_sec_decoder_top.sv @@
// Top level of the Hamming single-error-correcting decoder.
// Depends on hsd_pkg and instantiates hsd_front, hsd_queue and hsd_back.

// The decoder takes one 63-bit codeword per cycle while full is low and
// returns one result per codeword: the corrected data bits, the syndrome and
// an error flag. An accepted beat sits in the front syndrome register, then
// enters the two-entry queue and then reaches the result register, which
// drives the result ports. With pop held high the block sustains one beat per
// cycle. The front computes the syndrome with one parity tree per syndrome
// bit; the back flips the named position, packs the data bits and zeroes
// those at and above data_bits. A double error is miscorrected. Write
// cfg_wdata with cfg_we only while no beat is in flight.
module hamming_sec_decoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hsd_pkg::DBITS_W-1:0]     cfg_wdata,
    input  logic                            push,
    output logic                            full,
    input  logic [hsd_pkg::CODE_W-1:0]      codeword,
    output logic                            empty,
    input  logic                            pop,
    output logic [hsd_pkg::DATA_W-1:0]      data_out,
    output logic [hsd_pkg::POS_W-1:0]       error_position,
    output logic                            error_found
);

    hsd_pkg::hsd_q_status_t q_status;
    hsd_pkg::hsd_item_t     q_wdata;
    hsd_pkg::hsd_item_t     q_rdata;
    logic                   q_wr;
    logic                   q_rd;

    // Front: accept and classify.
    hsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .codeword (codeword),
        .q_status (q_status),
        .q_wr     (q_wr),
        .q_wdata  (q_wdata)
    );

    // Decoupling queue.
    hsd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wdata  (q_wdata),
        .rd     (q_rd),
        .rdata  (q_rdata),
        .status (q_status)
    );

    // Back: correct, extract and present results.
    hsd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .q_status       (q_status),
        .q_rdata        (q_rdata),
        .q_rd           (q_rd),
        .pop            (pop),
        .empty          (empty),
        .data_out       (data_out),
        .error_position (error_position),
        .error_found    (error_found)
    );

`ifndef SYNTHESIS
    // The error flag always agrees with the reported syndrome.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (error_found == (error_position != '0)))
        else $error("error_found disagrees with error_position");

    // The queue is never full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    // A stalled front beat is not lost: the block stays full until the queue drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !q_rd) |=> full)
        else $error("front stage dropped a stalled beat");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for hamming_sec_decoder_top: codewords go in, decoded beats come out.
// Depends on hsd_pkg and the decoder RTL. A scoreboard class predicts every result, and
// plain tasks drive the push handshake and the data_bits register; an always block pops.
`timescale 1ns / 1ps

module tb;

    import hsd_pkg::*;

    // One decoded beat as the result ports present it.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              found;
    } decoded_t;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_ITEMS = 166;

    // The syndrome is the XOR of the positions of all set code bits.
    function automatic logic [POS_W-1:0] code_syndrome(input logic [CODE_W-1:0] w);
        logic [POS_W-1:0] s;
        s = '0;
        for (int p = 1; p <= CODE_LEN; p++)
        begin
            if (w[p-1])
                s ^= POS_W'(p);
        end
        return s;
    endfunction

    // Places data bits at the non-power-of-two positions and sets the parity bits
    // so that the word has a zero syndrome.
    function automatic logic [CODE_W-1:0] make_codeword(input logic [DATA_W-1:0] d);
        logic [CODE_W-1:0] w;
        logic [POS_W-1:0]  s;
        int                idx;
        w = '0;
        idx = 0;
        for (int p = 1; p <= CODE_LEN; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                if (idx < DATA_W)
                    w[p-1] = d[idx];
                idx++;
            end
        end
        s = code_syndrome(w);
        for (int b = 0; b < PARITY_BITS; b++)
        begin
            if (s[b])
                w[(1 << b) - 1] = 1'b1;
        end
        return w;
    endfunction

    function automatic logic [CODE_W-1:0] random_bits();
        return CODE_W'({$urandom, $urandom});
    endfunction

    // Keeps the predicted decoder results in arrival order and checks each popped beat.
    class dec_scoreboard;
        decoded_t          pending_q[$];
        logic [DBITS_W-1:0] data_bits;
        int                errors;

        function new();
            data_bits = DATA_BITS_RESET;
            errors = 0;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // Corrects the word at the syndrome position and packs the delivered data bits.
        function decoded_t decode(input logic [CODE_W-1:0] cw);
            logic [CODE_W-1:0] w;
            logic [POS_W-1:0]  s;
            decoded_t          r;
            int                idx;
            w = cw;
            for (int p = CODE_LEN + 1; p <= CODE_W; p++)
            begin
                w[p-1] = 1'b0;
            end
            s = code_syndrome(w);
            if (s != '0)
                w[s-1] = ~w[s-1];
            r.data = '0;
            idx = 0;
            for (int p = 1; p <= CODE_LEN; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    if (idx < data_bits && idx < DATA_W)
                        r.data[idx] = w[p-1];
                    idx++;
                end
            end
            r.pos = s;
            r.found = (s != '0);
            return r;
        endfunction

        function void note_codeword(input logic [CODE_W-1:0] cw);
            pending_q.push_back(decode(cw));
        endfunction

        function void check_result(input logic [DATA_W-1:0] d, input logic [POS_W-1:0] pos,
                                   input logic found);
            decoded_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with nothing pending: data_out=%h error_position=%0d",
                         $time, d, pos);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (d !== want.data)
            begin
                $display("%0t: data_out expected %h actual %h", $time, want.data, d);
                errors++;
            end
            if (pos !== want.pos)
            begin
                $display("%0t: error_position expected %0d actual %0d", $time, want.pos, pos);
                errors++;
            end
            if (found !== want.found)
            begin
                $display("%0t: error_found expected %b actual %b", $time, want.found, found);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [DBITS_W-1:0]  cfg_wdata = '0;
    logic                push = 1'b0;
    logic                full;
    logic [CODE_W-1:0]   codeword = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [DATA_W-1:0]   data_out;
    logic [POS_W-1:0]    error_position;
    logic                error_found;

    dec_scoreboard sb = new();

    int   burst_left = 1;
    bit   gaps_on = 1'b1;
    int   idle_cycles = 0;
    logic [15:0] pop_pattern = 16'hFFFF;
    int   pattern_age = 0;

    always #10 clk = ~clk;

    hamming_sec_decoder_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .codeword       (codeword),
        .empty          (empty),
        .pop            (pop),
        .data_out       (data_out),
        .error_position (error_position),
        .error_found    (error_found)
    );

    // Receiver: checks each popped beat and stalls on a rotating pattern that is
    // reloaded now and then, sometimes with no stalls at all.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
                sb.check_result(data_out, error_position, error_found);
            pattern_age++;
            if (pattern_age >= 100)
            begin
                pattern_age = 0;
                if ($urandom_range(0, 3) == 0)
                    pop_pattern = 16'hFFFF;
                else
                    pop_pattern = 16'($urandom) | 16'h0001;
            end
            else
            begin
                pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
            end
            pop <= pop_pattern[0];
        end
    end

    // Watchdog: ends the run when neither side moves a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic idle_gap(input int n);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Sends one codeword, waits for the edge that accepts it, then applies the burst gaps.
    task automatic send_word(input logic [CODE_W-1:0] cw);
        push <= 1'b1;
        codeword <= cw;
        do @(posedge clk); while (full);
        sb.note_codeword(cw);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on && $urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 6));
        end
    endtask

    // Holds the sender off until every pending result has been popped.
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_data_bits(input logic [DBITS_W-1:0] v);
        drain();
        repeat (5) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.data_bits = v;
        cfg_we <= 1'b0;
    endtask

    // Mostly valid codewords with zero, one or two flipped bits, plus raw noise.
    function automatic logic [CODE_W-1:0] random_codeword();
        logic [CODE_W-1:0] w;
        int                pick;
        int                a;
        int                b;
        pick = $urandom_range(0, 99);
        w = make_codeword(DATA_W'({$urandom, $urandom}));
        a = $urandom_range(0, CODE_LEN - 1);
        b = $urandom_range(0, CODE_LEN - 1);
        if (pick < 45)
            w[a] = ~w[a];
        else if (pick < 60)
            w = w ^ (CODE_W'(1) << a) ^ (CODE_W'(1) << b);
        else if (pick >= 80)
            w = random_bits();
        return w;
    endfunction

    initial
    begin
        logic [CODE_W-1:0] w;
        logic [DBITS_W-1:0] setting;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset setting: extremes, each kind of error, parity positions.
        send_word('0);
        send_word('1);
        send_word(CODE_W'(1));
        send_word(CODE_W'(1) << 1);
        send_word(CODE_W'(1) << 2);
        send_word(CODE_W'(1) << 31);
        send_word(CODE_W'(1) << 62);
        send_word(CODE_W'({32{2'b01}}));
        send_word(CODE_W'({32{2'b10}}));
        send_word(make_codeword('1));
        w = make_codeword(DATA_W'({$urandom, $urandom}));
        send_word(w);
        send_word(w ^ (CODE_W'(1) << 3));
        send_word(w ^ (CODE_W'(1) << 15));
        send_word(w ^ (CODE_W'(1) << 62));
        send_word(w ^ (CODE_W'(1) << 4) ^ (CODE_W'(1) << 40));
        send_word(w ^ (CODE_W'(1) << 0) ^ (CODE_W'(1) << 1));

        // Directed part at the data_bits extremes.
        write_data_bits('0);
        send_word(make_codeword('1) ^ (CODE_W'(1) << 20));
        send_word('1);
        write_data_bits('1);
        send_word(make_codeword('1));
        send_word(w ^ (CODE_W'(1) << 7));
        write_data_bits(DBITS_W'(1));
        send_word(make_codeword('1) ^ (CODE_W'(1) << 2));
        send_word(make_codeword(DATA_W'(1)));

        // Random phases, each under its own data_bits setting.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: setting = DBITS_W'(1);
                1: setting = '0;
                2: setting = '1;
                3: setting = DBITS_W'(57);
                4: setting = DBITS_W'(58);
                5: setting = DBITS_W'(32);
                6: setting = DBITS_W'($urandom_range(2, 56));
                default: setting = DBITS_W'(57);
            endcase
            write_data_bits(setting);
            gaps_on = (ph != 2 && ph != 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 3 && n == PHASE_ITEMS / 2)
                    drain();
                send_word(random_codeword());
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/hsd_pkg.sv
hw/rtl/hsd_front.sv
hw/rtl/hsd_queue.sv
hw/rtl/hsd_back.sv
hw/rtl/hamming_sec_decoder_top.sv
test/tb.sv
